@@ rtl/iirdf2_pkg.sv @@
// Shared types, sizes and register codes of the direct form II IIR filter.
package iirdf2_pkg;

   localparam int FF_TAPS     = 4;   // b0 .. b(FF_TAPS-1)
   localparam int FB_TAPS     = 4;   // a1 .. a(FB_TAPS)
   localparam int NUM_COEF    = 8;

   localparam int SAMPLE_W    = 24;
   localparam int COEF_W      = 32;
   localparam int STATE_W     = 40;  // Q24.16
   localparam int FRAC_SHIFT  = 16;
   localparam int Q_SHIFT     = 30;  // Q2.30 coefficients
   localparam int SPLIT       = 20;  // state word is multiplied in two halves
   localparam int OP_W        = SPLIT + 1;
   localparam int MUL_W       = COEF_W + OP_W;
   localparam int PROD_W      = 72;
   localparam int TERM_W      = PROD_W - Q_SHIFT;
   localparam int ACC_W       = 44;
   localparam int YSH_W       = ACC_W - FRAC_SHIFT;

   localparam int CSR_IDX_W   = 4;
   localparam int COEF_IDX_W  = 3;

   localparam int DELAY_DEPTH = (FB_TAPS > FF_TAPS - 1) ? FB_TAPS : FF_TAPS - 1;
   localparam int DIDX_W      = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
   localparam int ISSUE_HALVES = 2 * (FB_TAPS + FF_TAPS - 1);
   localparam int CNT_W       = (ISSUE_HALVES > 1) ? $clog2(ISSUE_HALVES) : 1;

   // register indexes
   localparam int REG_FF_COEF_0 = 0;
   localparam int REG_FF_COEF_1 = 1;
   localparam int REG_FB_COEF_1 = 4;

   typedef logic signed [COEF_W-1:0]  coef_type;
   typedef logic signed [STATE_W-1:0] state_type;

   localparam coef_type COEF_RESET [NUM_COEF] = '{
      32'sd5766, 32'sd17298, 32'sd17298, 32'sd5766,
      -32'sd1760936591, 32'sd312888368, 32'sd374413774, 32'sd0
   };

   // tag that travels with each half-multiply through the shared unit
   typedef struct packed {
      logic valid;
      logic hi;      // upper half of the state word
      logic sel_y;   // feedforward sum, else feedback sum
   } mac_tag_type;

endpackage

@@ rtl/iir_direct_form_two_filter.sv @@
// Fourth-order direct form II IIR filter top level: coefficients, delay line, sequencer.
//
// Input items arrive on req_ (valid/ready) carrying one signed 24-bit sample.
// Each item yields exactly one result on rsp_ (valid/ready): the saturated
// 24-bit output and an overflow flag for saturation of w0 or of the output.
// Coefficients b0..b3, a1..a4 (Q2.30) are written through csr_write,
// csr_index and csr_wdata; indexes 8 and above are ignored.
// One 32x21 multiplier is shared by every tap: each tap takes two passes
// (low and high half of the 40-bit state word), so an item goes through
// the passes for the delay-line taps, a pipeline drain, a w0 saturation
// state, two passes for b0, a second drain and an output state. The idle
// state takes the next item once the last one has left the output state.
// req_ready is high only while the sequencer is idle, one item at a time.
// The output register holds a finished result while the receiver stalls;
// the next item may be accepted meanwhile and waits in its last cycle
// until the register is free.
// Synchronous reset restores the reset coefficients and clears the delay line.
module iir_direct_form_two_filter import iirdf2_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_sample_out,
   output logic                       rsp_overflow,
   input  logic                       csr_write,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [COEF_W-1:0]          csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_FEED, ST_DRAIN_W, ST_SAT_W, ST_B0_LO, ST_B0_HI, ST_DRAIN_Y, ST_FINISH
   } state_enum_type;

   localparam logic signed [ACC_W-1:0] W_MAX =
      {{(ACC_W-STATE_W+1){1'b0}}, {(STATE_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] W_MIN =
      {{(ACC_W-STATE_W+1){1'b1}}, {(STATE_W-1){1'b0}}};
   localparam logic signed [YSH_W-1:0] Y_MAX =
      {{(YSH_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [YSH_W-1:0] Y_MIN =
      {{(YSH_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};

   state_enum_type             state_ff;
   coef_type                   coef_ff [NUM_COEF];
   state_type                  delay_ff [DELAY_DEPTH];
   state_type                  w0_ff;
   logic [CNT_W-1:0]           cnt_ff;
   logic signed [ACC_W-1:0]    wacc_ff, yacc_ff;
   logic                       ovf_ff;
   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff;
   logic                       rsp_overflow_ff;

   mac_tag_type                op_tag, term_tag;
   logic signed [COEF_W-1:0]   op_coef;
   logic signed [OP_W-1:0]     op_data;
   logic signed [TERM_W-1:0]   term;
   logic                       mac_idle;

   logic [COEF_IDX_W-1:0]      cidx;
   logic [DIDX_W-1:0]          didx;
   logic                       tap_sel_y;
   state_type                  op_word;
   state_type                  w0_sat;
   logic                       w0_ovf;
   logic signed [YSH_W-1:0]    y_shift;
   logic signed [SAMPLE_W-1:0] y_sat;
   logic                       y_ovf;
   logic                       out_free;

   // tap selection for the delay-line passes
   always_comb begin
      int tap;
      tap = int'(cnt_ff >> 1);
      if (tap < FB_TAPS) begin
         cidx      = COEF_IDX_W'(REG_FB_COEF_1 + tap);
         didx      = DIDX_W'(tap);
         tap_sel_y = 1'b0;
      end else begin
         cidx      = COEF_IDX_W'(REG_FF_COEF_1 + tap - FB_TAPS);
         didx      = DIDX_W'(tap - FB_TAPS);
         tap_sel_y = 1'b1;
      end
   end

   always_comb begin
      op_tag  = '0;
      op_coef = coef_ff[cidx];
      op_word = delay_ff[didx];
      case (state_ff)
         ST_FEED: begin
            op_tag = '{valid: 1'b1, hi: cnt_ff[0], sel_y: tap_sel_y};
         end
         ST_B0_LO, ST_B0_HI: begin
            op_tag  = '{valid: 1'b1, hi: (state_ff == ST_B0_HI), sel_y: 1'b1};
            op_coef = coef_ff[COEF_IDX_W'(REG_FF_COEF_0)];
            op_word = w0_ff;
         end
         default: begin
            op_tag = '0;
         end
      endcase
      if (op_tag.hi) begin
         op_data = OP_W'($signed(op_word[STATE_W-1:SPLIT]));
      end else begin
         op_data = {1'b0, op_word[SPLIT-1:0]};
      end
   end

   iirdf2_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .op_tag   (op_tag),
      .op_coef  (op_coef),
      .op_data  (op_data),
      .term_tag (term_tag),
      .term     (term),
      .idle     (mac_idle)
   );

   always_comb begin
      w0_ovf = 1'b1;
      if (wacc_ff > W_MAX) begin
         w0_sat = W_MAX[STATE_W-1:0];
      end else if (wacc_ff < W_MIN) begin
         w0_sat = W_MIN[STATE_W-1:0];
      end else begin
         w0_sat = wacc_ff[STATE_W-1:0];
         w0_ovf = 1'b0;
      end
   end

   assign y_shift = yacc_ff[ACC_W-1:FRAC_SHIFT];

   always_comb begin
      y_ovf = 1'b1;
      if (y_shift > Y_MAX) begin
         y_sat = Y_MAX[SAMPLE_W-1:0];
      end else if (y_shift < Y_MIN) begin
         y_sat = Y_MIN[SAMPLE_W-1:0];
      end else begin
         y_sat = y_shift[SAMPLE_W-1:0];
         y_ovf = 1'b0;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         for (int i = 0; i < NUM_COEF; i++) begin
            coef_ff[i] <= COEF_RESET[i];
         end
         for (int i = 0; i < DELAY_DEPTH; i++) begin
            delay_ff[i] <= '0;
         end
      end else begin
         if (csr_write && (int'(csr_index) < NUM_COEF)) begin
            coef_ff[csr_index[COEF_IDX_W-1:0]] <= csr_wdata;
         end
         // the final state reloads the output register itself
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         if (term_tag.valid) begin
            if (term_tag.sel_y) begin
               yacc_ff <= yacc_ff + ACC_W'(term);
            end else begin
               wacc_ff <= wacc_ff - ACC_W'(term);
            end
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  wacc_ff  <= ACC_W'(req_sample_in) <<< FRAC_SHIFT;
                  yacc_ff  <= '0;
                  cnt_ff   <= '0;
                  state_ff <= ST_FEED;
               end
            end
            ST_FEED: begin
               if (int'(cnt_ff) == ISSUE_HALVES - 1) begin
                  state_ff <= ST_DRAIN_W;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_DRAIN_W: begin
               if (mac_idle) begin
                  state_ff <= ST_SAT_W;
               end
            end
            ST_SAT_W: begin
               w0_ff       <= w0_sat;
               ovf_ff      <= w0_ovf;
               delay_ff[0] <= w0_sat;
               for (int i = 1; i < DELAY_DEPTH; i++) begin
                  delay_ff[i] <= delay_ff[i-1];
               end
               state_ff <= ST_B0_LO;
            end
            ST_B0_LO: begin
               state_ff <= ST_B0_HI;
            end
            ST_B0_HI: begin
               state_ff <= ST_DRAIN_Y;
            end
            ST_DRAIN_Y: begin
               if (mac_idle) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_sample_ff   <= y_sat;
                  rsp_overflow_ff <= ovf_ff | y_ovf;
                  state_ff        <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_overflow   = rsp_overflow_ff;

`ifndef SYNTHESIS
   // the shared unit only returns terms while an item is being worked on
   a_term_only_busy: assert property (@(posedge clock) disable iff (reset)
      term_tag.valid |-> (state_ff != ST_IDLE))
      else $error("multiply term returned while idle");

   // w0 is taken only once every feedback term is in
   a_sat_after_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SAT_W) |-> mac_idle)
      else $error("w0 saturated with terms still in flight");

   // an accepted item starts the tap passes at once
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_FEED))
      else $error("accepted item did not start");

   // a new result appears only out of the final state
   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(state_ff) == ST_FINISH))
      else $error("result without a finished item");
`endif

endmodule

@@ rtl/iirdf2_mac.sv @@
// Shared multiply unit: coefficient times one state half, rebuilt into a floored Q26.16 term.
module iirdf2_mac import iirdf2_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  mac_tag_type              op_tag,
   input  logic signed [COEF_W-1:0] op_coef,
   input  logic signed [OP_W-1:0]   op_data,
   output mac_tag_type              term_tag,
   output logic signed [TERM_W-1:0] term,
   output logic                     idle
);

   mac_tag_type              tag1_ff, tag2_ff;
   logic signed [MUL_W-1:0]  mul_ff, mul_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;

   assign mul_in = op_coef * op_data;

   // low half arrives first, high half is added in at 2^20
   always_comb begin
      if (tag1_ff.hi) begin
         prod_in = prod_ff + (PROD_W'(mul_ff) <<< SPLIT);
      end else begin
         prod_in = PROD_W'(mul_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
      end else begin
         tag1_ff <= op_tag;
         tag2_ff <= tag1_ff;
      end
   end

   always_ff @(posedge clock) begin
      mul_ff <= mul_in;
      if (tag1_ff.valid) begin
         prod_ff <= prod_in;
      end
   end

   assign term         = prod_ff[PROD_W-1:Q_SHIFT];
   assign term_tag     = '{valid: tag2_ff.valid & tag2_ff.hi, hi: tag2_ff.hi,
                           sel_y: tag2_ff.sel_y};
   assign idle         = !tag1_ff.valid && !tag2_ff.valid;

endmodule
